// File: rtl/gn3o_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3o_pkg
// Shared types, constants and helpers of the fractal gradient noise block.
// ----------------------------------------------------------------------------
package gn3o_pkg;

    localparam int GN_MAX_OCTAVES = 3;
    localparam int GN_BASE_POWER  = 2;

    typedef struct packed {
        logic        command;
        logic [1:0]  octave_select;
        logic [11:0] grid_index;
        logic [15:0] gradient_x;
        logic [15:0] gradient_y;
        logic [15:0] gradient_z;
        logic [15:0] point_x;
        logic [15:0] point_y;
        logic [15:0] point_z;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  octave_number;
        logic [19:0] octave_value;
        logic [15:0] clamped_total;
        logic        last_octave;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SM0,
        ST_SM1,
        ST_ADDR,
        ST_DOT,
        ST_LERP,
        ST_EMIT
    } t_state;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Store offset of the first gradient of one octave.
    function automatic logic [31:0] octave_base(input logic [1:0] oct, input int bp);
        logic [31:0] acc;
        acc = 32'd0;
        for (int k = 0; k < 4; k++) begin
            if (k < int'(oct)) begin
                acc = acc + (32'd1 << (3 * (bp + k)));
            end
        end
        return acc;
    endfunction

endpackage

// File: rtl/gn3o_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3o_store
// Gradient memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gn3o_store #(
    parameter int DEPTH = 4672,
    parameter int AW    = 13
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [47:0]   i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [47:0]   o_rd_data
);

    logic [47:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

// File: rtl/gradient_noise_3d_octaves.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_3d_octaves
// Fractal 3D gradient noise over loaded per-octave gradient grids.
// ----------------------------------------------------------------------------
// A load transaction writes one gradient and is accepted only when the block
// is idle. A query transaction runs one shared multiplier under a sequencer:
// per octave, the smoothstep of each axis, then for each of the eight corners
// an address step and a dot product (one memory read and three products),
// then the blend steps and an emit step. The emit step waits only when the
// previous result is still held in the output register. The gradient memory
// is not cleared after reset.
module gradient_noise_3d_octaves
    import gn3o_pkg::*;
#(
    parameter int MAX_OCTAVES = GN_MAX_OCTAVES,
    parameter int BASE_POWER  = GN_BASE_POWER
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_data
);

    localparam int STORE_DEPTH =
        ((1 << (3 * BASE_POWER)) * ((1 << (3 * MAX_OCTAVES)) - 1)) / 7;
    localparam int AW = $clog2(STORE_DEPTH);

    t_state r_state, n_state;
    logic [1:0]  r_act_oct;
    logic [1:0]  r_oct, r_nlast, r_ax;
    logic [2:0]  r_corner, r_step;
    logic [15:0] r_pt [3];
    logic [16:0] r_sm [3];
    logic [31:0] r_t2;
    logic signed [34:0] r_acc;
    logic signed [20:0] r_v [8];
    logic signed [22:0] r_total;
    logic [AW-1:0] r_base;
    logic          r_out_valid;
    t_out_item     r_out;

    logic [47:0] rd_data;
    logic [AW-1:0] rd_addr;
    logic [3:0]  s;
    logic [15:0] frac [3];
    logic [15:0] frac_ax;
    logic signed [32:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [51:0] prod;
    logic signed [34:0] acc_n;
    logic [2:0]  la, lb;
    logic [16:0] lsm;
    logic signed [20:0] lerp_res;
    logic signed [21:0] ldiff;
    logic signed [22:0] za_ext, val_r, val_s;
    logic signed [22:0] total_n, clamp_t;
    logic wr_en;
    logic [31:0] wr_idx;
    logic [1:0] n_oct_cnt;
    logic emit_go;

    assign s = 4'(BASE_POWER) + {2'b00, r_oct};

    always_comb begin
        logic [31:0] idx;
        logic [15:0] cl;
        logic [15:0] ci;
        logic [15:0] mask;
        idx  = 32'd0;
        mask = 16'((32'd1 << s) - 32'd1);
        for (int a = 0; a < 3; a++) begin
            frac[a] = 16'({r_pt[a], 16'd0} >> (16 - s));
            cl = r_pt[a] >> (16 - s);
            ci = r_corner[a] ? ((cl + 16'd1) & mask) : cl;
            idx = idx | (32'(ci) << (a * s));
        end
        rd_addr = AW'(idx + 32'(r_base));
    end

    assign frac_ax = frac[r_ax];

    always_comb begin
        la = 3'd0; lb = 3'd1; lsm = r_sm[0];
        case (r_step)
            3'd0: begin la = 3'd0; lb = 3'd1; lsm = r_sm[0]; end
            3'd1: begin la = 3'd2; lb = 3'd3; lsm = r_sm[0]; end
            3'd2: begin la = 3'd4; lb = 3'd5; lsm = r_sm[0]; end
            3'd3: begin la = 3'd6; lb = 3'd7; lsm = r_sm[0]; end
            3'd4: begin la = 3'd0; lb = 3'd2; lsm = r_sm[1]; end
            3'd5: begin la = 3'd4; lb = 3'd6; lsm = r_sm[1]; end
            3'd6: begin la = 3'd0; lb = 3'd4; lsm = r_sm[2]; end
            default: begin la = 3'd0; lb = 3'd1; lsm = r_sm[0]; end
        endcase
    end

    assign ldiff = 22'(r_v[lb]) - 22'(r_v[la]);

    always_comb begin
        mul_a = 33'sd0;
        mul_b = 19'sd0;
        case (r_state)
            ST_SM0: begin
                mul_a = $signed({17'd0, frac_ax});
                mul_b = $signed({3'd0, frac_ax});
            end
            ST_SM1: begin
                mul_a = $signed({1'b0, r_t2});
                mul_b = 19'sd196608 - $signed({2'd0, frac_ax, 1'b0});
            end
            ST_DOT: begin
                mul_a = 33'($signed(rd_data[16*r_ax +: 16]));
                mul_b = $signed({3'd0, frac_ax}) - (r_corner[r_ax] ? 19'sd65536 : 19'sd0);
            end
            ST_LERP: begin
                mul_a = 33'(ldiff);
                mul_b = $signed({2'd0, lsm});
            end
            default: begin
                mul_a = 33'sd0;
                mul_b = 19'sd0;
            end
        endcase
    end

    assign prod     = 52'(mul_a) * 52'(mul_b);
    assign acc_n    = r_acc + 35'(prod);
    assign lerp_res = 21'(r_v[la] + 21'((prod + 52'sd32768) >>> 16));

    assign za_ext  = 23'(r_v[0]);
    assign val_r   = (za_ext + (23'sd1 <<< ({1'b0, r_oct} + 3'd1)))
                     >>> ({1'b0, r_oct} + 3'd2);
    assign val_s   = (val_r > 23'sd524287) ? 23'sd524287 :
                     (val_r < -23'sd524288) ? -23'sd524288 : val_r;
    assign total_n = r_total + val_s;
    assign clamp_t = (total_n > 23'sd16384) ? 23'sd16384 :
                     (total_n < -23'sd16384) ? -23'sd16384 : total_n;

    assign emit_go    = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == ST_IDLE);

    assign n_oct_cnt = (r_act_oct == 2'd0) ? 2'd1 :
                       (int'(r_act_oct) > MAX_OCTAVES) ? 2'(MAX_OCTAVES) : r_act_oct;

    assign wr_idx = octave_base(i_in_data.octave_select, BASE_POWER)
                    + 32'(i_in_data.grid_index);
    assign wr_en  = i_in_valid && o_in_ready && (i_in_data.command == CMD_LOAD)
                    && (int'(i_in_data.octave_select) < MAX_OCTAVES)
                    && (32'(i_in_data.grid_index)
                        < (32'd1 << (3 * (BASE_POWER + int'(i_in_data.octave_select)))))
                    && (wr_idx < 32'(STORE_DEPTH));

    gn3o_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(wr_idx)),
        .i_wr_data ({i_in_data.gradient_z, i_in_data.gradient_y, i_in_data.gradient_x}),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_in_data.command == CMD_QUERY) begin
                    n_state = ST_SM0;
                end
            end
            ST_SM0:  n_state = ST_SM1;
            ST_SM1:  n_state = (r_ax == 2'd2) ? ST_ADDR : ST_SM0;
            ST_ADDR: n_state = ST_DOT;
            ST_DOT: begin
                if (r_ax == 2'd2) begin
                    n_state = (r_corner == 3'd7) ? ST_LERP : ST_ADDR;
                end
            end
            ST_LERP: n_state = (r_step == 3'd6) ? ST_EMIT : ST_LERP;
            ST_EMIT: begin
                if (emit_go) begin
                    n_state = (r_oct == r_nlast) ? ST_IDLE : ST_SM0;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_act_oct   <= 2'd3;
            r_out_valid <= 1'b0;
            r_ax        <= 2'd0;
            r_corner    <= 3'd0;
            r_step      <= 3'd0;
            r_oct       <= 2'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_act_oct <= i_cfg_data;
            end
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_ax     <= 2'd0;
                    r_oct    <= 2'd0;
                    r_corner <= 3'd0;
                    r_step   <= 3'd0;
                end
                ST_SM1: begin
                    r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                end
                ST_DOT: begin
                    r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                    if (r_ax == 2'd2) begin
                        r_corner <= r_corner + 3'd1;
                    end
                end
                ST_LERP: begin
                    r_step <= (r_step == 3'd6) ? 3'd0 : r_step + 3'd1;
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        r_oct <= r_oct + 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_pt[0] <= i_in_data.point_x;
                r_pt[1] <= i_in_data.point_y;
                r_pt[2] <= i_in_data.point_z;
                r_nlast <= n_oct_cnt - 2'd1;
                r_total <= 23'sd0;
                r_base  <= '0;
            end
            ST_SM0:  r_t2 <= prod[31:0];
            ST_SM1:  r_sm[r_ax] <= 17'((prod + 52'sd2147483648) >>> 32);
            ST_ADDR: r_acc <= 35'sd0;
            ST_DOT: begin
                r_acc <= acc_n;
                if (r_ax == 2'd2) begin
                    r_v[r_corner] <= 21'((acc_n + 35'sd8192) >>> 14);
                end
            end
            ST_LERP: r_v[la] <= lerp_res;
            ST_EMIT: begin
                if (emit_go) begin
                    r_total <= total_n;
                    r_base  <= r_base + AW'(32'd1 << (3 * s));
                    r_out.octave_number <= r_oct;
                    r_out.octave_value  <= val_s[19:0];
                    r_out.clamped_total <= (r_oct == r_nlast) ? clamp_t[15:0] : 16'd0;
                    r_out.last_octave   <= (r_oct == r_nlast);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_mid_total_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last_octave |-> o_out_data.clamped_total == 16'd0)
        else $error("clamped total not zero on an inner octave result");

    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last_octave |-> r_state != ST_IDLE)
        else $error("query ended before its last octave");

    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_EMIT)
        else $error("result raised outside the emit step");
`endif

endmodule
